// File: rtl/core/nsr_pkg.sv
package nsr_pkg;

    localparam int unsigned DEF_MAX_LENGTH = 128;
    localparam int unsigned DEF_MAX_FIELDS = 16;

    localparam logic [7:0] C_DOLLAR = 8'h24;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_LF     = 8'h0A;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_STAR   = 8'h2A;

    localparam logic [6:0] C_POS_MAX = 7'd127;

    typedef enum logic [2:0] {
        K_NONE   = 3'd0,
        K_CHAR   = 3'd1,
        K_FEND   = 3'd2,
        K_ACCEPT = 3'd3,
        K_REJECT = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        E_NONE     = 3'd0,
        E_TERM     = 3'd1,
        E_OVERFLOW = 3'd2,
        E_NOSTAR   = 3'd3,
        E_UNKNOWN  = 3'd4,
        E_CHECKSUM = 3'd5,
        E_FIELDS   = 3'd6
    } t_err;

    typedef enum logic [1:0] {
        M_UNKNOWN = 2'd0,
        M_PMTK    = 2'd1,
        M_GPRMC   = 2'd2
    } t_msg;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_char;
        logic [4:0] field_number;
        logic [6:0] char_position;
        t_msg       message_kind;
        t_err       error_code;
        logic       checksum_good;
    } t_result;

endpackage

// File: rtl/core/nmea_sentence_receiver_unit.sv
// channel | valid      | stall / ready | payload
// --------+------------+---------------+------------------------------------------
// in      | i_in_valid | o_in_stall    | i_rx_byte
// out     | o_out_valid| i_out_stall   | o_kind .. o_checksum_good (one per item)
// cfg     | i_cfg_valid| o_cfg_ready   | i_cfg_data (enforce_checksum)
//
// one byte a cycle while o_in_stall is low; each accepted byte gives exactly one result item,
// built by the per-byte parser logic from the sentence state and held in the result register.
// synchronous active-low reset clears the sentence state, enforce_checksum resets to 1.
// a two-entry output (result register plus skid register) keeps accepting one more byte
// while the output is stalled; o_in_stall rises only when both are full.
module nmea_sentence_receiver_unit #(
    parameter int unsigned MAX_LENGTH = nsr_pkg::DEF_MAX_LENGTH,
    parameter int unsigned MAX_FIELDS = nsr_pkg::DEF_MAX_FIELDS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_kind,
    output logic [7:0] o_data_char,
    output logic [4:0] o_field_number,
    output logic [6:0] o_char_position,
    output logic [1:0] o_message_kind,
    output logic [2:0] o_error_code,
    output logic       o_checksum_good,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);
    import nsr_pkg::*;

    localparam logic [7:0] LEN_MAX = 8'(MAX_LENGTH);
    localparam logic [4:0] FLD_MAX = 5'(MAX_FIELDS);

    function automatic logic [7:0] pmtk_char(input logic [7:0] idx);
        case (idx)
            8'd0:    pmtk_char = 8'h50;
            8'd1:    pmtk_char = 8'h4D;
            8'd2:    pmtk_char = 8'h54;
            default: pmtk_char = 8'h4B;
        endcase
    endfunction

    function automatic logic [7:0] gprmc_char(input logic [7:0] idx);
        case (idx)
            8'd0:    gprmc_char = 8'h47;
            8'd1:    gprmc_char = 8'h50;
            8'd2:    gprmc_char = 8'h52;
            8'd3:    gprmc_char = 8'h4D;
            default: gprmc_char = 8'h43;
        endcase
    endfunction

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            hex_value = 5'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            hex_value = 5'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            hex_value = 5'(c - 8'h57);
        end else begin
            hex_value = 5'd16;
        end
    endfunction

    function automatic t_msg resolve(input logic [1:0] flags, input logic [7:0] len);
        if (flags[1] && len >= 8'd5) begin
            resolve = M_GPRMC;
        end else if (flags[0] && len >= 8'd4) begin
            resolve = M_PMTK;
        end else begin
            resolve = M_UNKNOWN;
        end
    endfunction

    logic       r_enforce;
    logic       r_in_sent, n_in_sent;
    logic       r_seen_cr, n_seen_cr;
    logic       r_seen_star, n_seen_star;
    logic [7:0] r_xor, n_xor;
    logic [7:0] r_rx_sum, n_rx_sum;
    logic [1:0] r_hex_cnt, n_hex_cnt;
    logic       r_hex_bad, n_hex_bad;
    logic [7:0] r_len, n_len;
    logic [4:0] r_fld, n_fld;
    logic [6:0] r_pos, n_pos;
    logic [1:0] r_flags, n_flags;

    t_result    r_out, r_skid, res;
    logic       r_out_valid, r_skid_valid;

    logic       accept;
    logic [7:0] b;
    logic [7:0] len_inc;
    logic [4:0] hv;
    logic       good;
    t_msg       mk;
    t_err       err;

    assign b           = i_rx_byte;
    assign o_in_stall  = r_skid_valid;
    assign accept      = i_in_valid && !r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign len_inc     = r_len + 8'd1;
    assign hv          = hex_value(b);

    always_comb begin
        n_in_sent   = r_in_sent;
        n_seen_cr   = r_seen_cr;
        n_seen_star = r_seen_star;
        n_xor       = r_xor;
        n_rx_sum    = r_rx_sum;
        n_hex_cnt   = r_hex_cnt;
        n_hex_bad   = r_hex_bad;
        n_len       = r_len;
        n_fld       = r_fld;
        n_pos       = r_pos;
        n_flags     = r_flags;
        res         = '0;
        mk          = M_UNKNOWN;
        err         = E_NONE;
        good        = 1'b0;

        if (!r_in_sent) begin
            if (b == C_DOLLAR) begin
                n_in_sent   = 1'b1;
                n_seen_cr   = 1'b0;
                n_seen_star = 1'b0;
                n_xor       = '0;
                n_rx_sum    = '0;
                n_hex_cnt   = '0;
                n_hex_bad   = 1'b0;
                n_len       = '0;
                n_fld       = '0;
                n_pos       = '0;
                n_flags     = 2'b11;
            end
        end else if (r_seen_cr) begin
            mk   = resolve(r_flags, r_len);
            good = r_seen_star && (r_hex_cnt == 2'd2) && !r_hex_bad && (r_rx_sum == r_xor);
            if (b != C_LF) begin
                err = E_TERM;
            end else if (r_len >= LEN_MAX) begin
                err = E_OVERFLOW;
            end else if (!r_seen_star) begin
                err = E_NOSTAR;
            end else if (mk == M_UNKNOWN) begin
                err = E_UNKNOWN;
            end else if (r_enforce && !good) begin
                err = E_CHECKSUM;
            end else if (r_fld >= FLD_MAX) begin
                err = E_FIELDS;
            end
            res.kind          = (err != E_NONE) ? K_REJECT : K_ACCEPT;
            res.field_number  = r_fld;
            res.message_kind  = mk;
            res.error_code    = err;
            res.checksum_good = good;
            n_in_sent   = 1'b0;
            n_seen_cr   = 1'b0;
            n_seen_star = 1'b0;
            n_xor       = '0;
            n_rx_sum    = '0;
            n_hex_cnt   = '0;
            n_hex_bad   = 1'b0;
            n_len       = '0;
            n_fld       = '0;
            n_pos       = '0;
            n_flags     = 2'b11;
        end else if (b == C_CR) begin
            n_seen_cr = 1'b1;
        end else if (r_len < LEN_MAX) begin
            if (r_len < 8'd4 && b != pmtk_char(r_len)) begin
                n_flags[0] = 1'b0;
            end
            if (r_len < 8'd5 && b != gprmc_char(r_len)) begin
                n_flags[1] = 1'b0;
            end
            n_len = len_inc;
            if (len_inc < LEN_MAX) begin
                if (r_seen_star) begin
                    if (hv[4] || r_hex_cnt >= 2'd2) begin
                        n_hex_bad = 1'b1;
                    end else begin
                        n_rx_sum = {r_rx_sum[3:0], hv[3:0]};
                    end
                    if (r_hex_cnt < 2'd3) begin
                        n_hex_cnt = r_hex_cnt + 2'd1;
                    end
                end else begin
                    mk                 = resolve(n_flags, len_inc);
                    res.field_number   = r_fld;
                    res.char_position  = r_pos;
                    res.message_kind   = mk;
                    if (b == C_STAR) begin
                        n_seen_star = 1'b1;
                        res.kind    = K_FEND;
                    end else if (b == C_COMMA) begin
                        n_xor    = r_xor ^ b;
                        res.kind = K_FEND;
                        if (r_fld < FLD_MAX) begin
                            n_fld = r_fld + 5'd1;
                        end
                        n_pos = '0;
                    end else begin
                        n_xor         = r_xor ^ b;
                        res.kind      = K_CHAR;
                        res.data_char = b;
                        if (r_pos < C_POS_MAX) begin
                            n_pos = r_pos + 7'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enforce   <= 1'b1;
            r_in_sent   <= 1'b0;
            r_seen_cr   <= 1'b0;
            r_seen_star <= 1'b0;
            r_xor       <= '0;
            r_rx_sum    <= '0;
            r_hex_cnt   <= '0;
            r_hex_bad   <= 1'b0;
            r_len       <= '0;
            r_fld       <= '0;
            r_pos       <= '0;
            r_flags     <= 2'b11;
        end else begin
            if (i_cfg_valid) begin
                r_enforce <= i_cfg_data;
            end
            if (accept) begin
                r_in_sent   <= n_in_sent;
                r_seen_cr   <= n_seen_cr;
                r_seen_star <= n_seen_star;
                r_xor       <= n_xor;
                r_rx_sum    <= n_rx_sum;
                r_hex_cnt   <= n_hex_cnt;
                r_hex_bad   <= n_hex_bad;
                r_len       <= n_len;
                r_fld       <= n_fld;
                r_pos       <= n_pos;
                r_flags     <= n_flags;
            end
        end
    end

    // result register with skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= res;
            end
        end else if (accept) begin
            r_skid <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_data_char     = r_out.data_char;
    assign o_field_number  = r_out.field_number;
    assign o_char_position = r_out.char_position;
    assign o_message_kind  = r_out.message_kind;
    assign o_error_code    = r_out.error_code;
    assign o_checksum_good = r_out.checksum_good;

endmodule
